// ===== hw/rtl/dq_pkg.sv =====
// Shared types and constants for the double-ended queue core.
`default_nettype none

package dq_pkg;

  localparam int RING_DEPTH = 64;
  localparam int PTR_W      = 6;
  localparam int OCC_W      = 7;
  localparam int WORD_W     = 32;
  localparam int KIND_W     = 3;
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef enum logic [KIND_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_SHOW       = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [WORD_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    status_t           status;
    logic [WORD_W-1:0] word;
    logic              last;
  } res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dq_front.sv =====
// Front end: accepts input words, drops unknown kinds and queues commands.
`default_nettype none

module dq_front (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_tvalid,
  output logic                               in_tready,
  input  wire logic [dq_pkg::WORD_W-1:0]     in_tdata,  // [31:0] value
  input  wire logic [dq_pkg::KIND_W-1:0]     in_tuser,  // [2:0] kind
  output logic                               cmd_valid,
  input  wire logic                          cmd_ready,
  output dq_pkg::cmd_t                       cmd
);

  dq_pkg::cmd_t                       cmdq_r [dq_pkg::CMDQ_DEPTH];
  logic [dq_pkg::CMDQ_PTR_W-1:0]      wr_ptr_r, wr_ptr_nxt;
  logic [dq_pkg::CMDQ_PTR_W-1:0]      rd_ptr_r, rd_ptr_nxt;
  logic [dq_pkg::CMDQ_CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                               kind_ok;
  logic                               enq;
  logic                               deq;

  // Kinds outside the operation list are taken and discarded.
  assign kind_ok   = (in_tuser <= dq_pkg::KIND_W'(dq_pkg::OP_SHOW));
  assign in_tready = (cnt_r != dq_pkg::CMDQ_CNT_W'(dq_pkg::CMDQ_DEPTH));
  assign enq       = in_tvalid && in_tready && kind_ok;
  assign cmd_valid = (cnt_r != '0);
  assign deq       = cmd_valid && cmd_ready;
  assign cmd       = cmdq_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (enq) begin
      wr_ptr_nxt = (wr_ptr_r == dq_pkg::CMDQ_PTR_W'(dq_pkg::CMDQ_DEPTH - 1)) ? '0
                   : wr_ptr_r + 1'b1;
    end
    if (deq) begin
      rd_ptr_nxt = (rd_ptr_r == dq_pkg::CMDQ_PTR_W'(dq_pkg::CMDQ_DEPTH - 1)) ? '0
                   : rd_ptr_r + 1'b1;
    end
    if (enq && !deq) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (deq && !enq) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (enq) begin
      cmdq_r[wr_ptr_r] <= '{op: dq_pkg::op_t'(in_tuser), value: in_tdata};
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/dq_back.sv =====
// Back end: ring store, front pointer and fill count, and the result queue.
`default_nettype none

module dq_back #(
  parameter int CAPACITY = 64
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cmd_valid,
  output logic                               cmd_ready,
  input  wire dq_pkg::cmd_t                  cmd,
  output logic                               out_tvalid,
  input  wire logic                          out_tready,
  output logic [dq_pkg::WORD_W-1:0]          out_tdata,  // [31:0] word
  output logic [1:0]                         out_tuser,  // [1:0] status
  output logic                               out_tlast
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_SHOW = 2'b10
  } state_t;

  state_t                          state_r, state_nxt;
  logic [dq_pkg::PTR_W-1:0]        front_r, front_nxt;
  logic [dq_pkg::OCC_W-1:0]        occ_r, occ_nxt;
  logic [dq_pkg::PTR_W-1:0]        cnt_r, cnt_nxt;

  // Ring store and its registered read port.
  logic [dq_pkg::WORD_W-1:0]       mem [dq_pkg::RING_DEPTH];
  logic [dq_pkg::WORD_W-1:0]       rdata_r;
  logic                            we;
  logic [dq_pkg::PTR_W-1:0]        waddr;
  logic                            re;
  logic [dq_pkg::PTR_W-1:0]        raddr;

  // A read in flight lands in the result queue on the following cycle.
  logic                            fly_r, fly_nxt;
  logic                            fly_last_r, fly_last_nxt;

  // Two-entry result queue.
  dq_pkg::res_t                    oq_r [2];
  logic                            oq_wr_r, oq_rd_r;
  logic [1:0]                      oq_cnt_r, oq_cnt_nxt;
  logic                            deq;
  logic                            enq;
  dq_pkg::res_t                    enq_res;
  logic                            dir_vld;
  dq_pkg::res_t                    dir_res;
  logic [2:0]                      room;
  logic                            can_issue;
  logic                            full;
  logic                            empty;
  logic                            show_last;

  assign full      = (occ_r >= dq_pkg::OCC_W'(CAPACITY));
  assign empty     = (occ_r == '0);
  assign deq       = (oq_cnt_r != '0) && out_tready;
  assign room      = {1'b0, oq_cnt_r} + 3'(fly_r) - 3'(deq);
  assign can_issue = (room <= 3'd1);
  assign show_last = ((dq_pkg::OCC_W'(cnt_r) + 1'b1) == occ_r);

  always_comb begin
    state_nxt    = state_r;
    front_nxt    = front_r;
    occ_nxt      = occ_r;
    cnt_nxt      = cnt_r;
    fly_nxt      = 1'b0;
    fly_last_nxt = fly_last_r;
    cmd_ready    = 1'b0;
    we           = 1'b0;
    waddr        = front_r;
    re           = 1'b0;
    raddr        = front_r;
    dir_vld      = 1'b0;
    dir_res      = '{status: dq_pkg::ST_OK, word: '0, last: 1'b1};
    case (state_r)
      S_IDLE: begin
        if (cmd_valid && can_issue) begin
          case (cmd.op)
            dq_pkg::OP_PUSH_FRONT, dq_pkg::OP_PUSH_BACK: begin
              if (!fly_r) begin
                cmd_ready = 1'b1;
                dir_vld   = 1'b1;
                if (full) begin
                  dir_res.status = dq_pkg::ST_FULL;
                end else begin
                  we      = 1'b1;
                  occ_nxt = occ_r + 1'b1;
                  if (cmd.op == dq_pkg::OP_PUSH_FRONT) begin
                    front_nxt = front_r - 1'b1;
                    waddr     = front_r - 1'b1;
                  end else begin
                    waddr = front_r + occ_r[dq_pkg::PTR_W-1:0];
                  end
                end
              end
            end
            dq_pkg::OP_POP_FRONT, dq_pkg::OP_POP_BACK: begin
              if (empty) begin
                if (!fly_r) begin
                  cmd_ready      = 1'b1;
                  dir_vld        = 1'b1;
                  dir_res.status = dq_pkg::ST_EMPTY;
                end
              end else begin
                cmd_ready    = 1'b1;
                re           = 1'b1;
                fly_nxt      = 1'b1;
                fly_last_nxt = 1'b1;
                occ_nxt      = occ_r - 1'b1;
                if (cmd.op == dq_pkg::OP_POP_FRONT) begin
                  front_nxt = front_r + 1'b1;
                end else begin
                  raddr = front_r + occ_r[dq_pkg::PTR_W-1:0] - 1'b1;
                end
              end
            end
            dq_pkg::OP_SHOW: begin
              if (empty) begin
                if (!fly_r) begin
                  cmd_ready      = 1'b1;
                  dir_vld        = 1'b1;
                  dir_res.status = dq_pkg::ST_EMPTY;
                end
              end else begin
                cmd_ready = 1'b1;
                cnt_nxt   = '0;
                state_nxt = S_SHOW;
              end
            end
            default: begin
              cmd_ready = 1'b1;
            end
          endcase
        end
      end
      S_SHOW: begin
        if (can_issue) begin
          re           = 1'b1;
          raddr        = front_r + cnt_r;
          fly_nxt      = 1'b1;
          fly_last_nxt = show_last;
          cnt_nxt      = cnt_r + 1'b1;
          if (show_last) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Direct results are only produced when no read is landing this cycle.
  assign enq     = fly_r || dir_vld;
  assign enq_res = fly_r ? dq_pkg::res_t'{status: dq_pkg::ST_OK, word: rdata_r,
                                          last: fly_last_r}
                         : dir_res;

  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (enq && !deq) begin
      oq_cnt_nxt = oq_cnt_r + 1'b1;
    end else if (deq && !enq) begin
      oq_cnt_nxt = oq_cnt_r - 1'b1;
    end
  end

  assign out_tvalid = (oq_cnt_r != '0);
  assign out_tdata  = oq_r[oq_rd_r].word;
  assign out_tuser  = oq_r[oq_rd_r].status;
  assign out_tlast  = oq_r[oq_rd_r].last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      front_r  <= '0;
      occ_r    <= '0;
      cnt_r    <= '0;
      fly_r    <= 1'b0;
      oq_wr_r  <= 1'b0;
      oq_rd_r  <= 1'b0;
      oq_cnt_r <= '0;
    end else begin
      state_r  <= state_nxt;
      front_r  <= front_nxt;
      occ_r    <= occ_nxt;
      cnt_r    <= cnt_nxt;
      fly_r    <= fly_nxt;
      oq_cnt_r <= oq_cnt_nxt;
      if (enq) begin
        oq_wr_r <= ~oq_wr_r;
      end
      if (deq) begin
        oq_rd_r <= ~oq_rd_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    fly_last_r <= fly_last_nxt;
    if (enq) begin
      oq_r[oq_wr_r] <= enq_res;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= cmd.value;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= dq_pkg::OCC_W'(CAPACITY))
    else $error("fill count beyond capacity");

  a_oq_room: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, oq_cnt_r} + 3'(fly_r)) <= 3'd2)
    else $error("result queue overcommitted");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    enq |-> ((oq_cnt_r != 2'd2) || deq))
    else $error("result queue overflow");

  a_show_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHOW) |-> (occ_r != '0))
    else $error("showing an empty queue");

  a_single_source: assert property (@(posedge clk) disable iff (!rst_n)
    !(fly_r && dir_vld))
    else $error("two results written in one cycle");

endmodule

`default_nettype wire

// ===== hw/rtl/double_ended_queue_core.sv =====
// Top level of the double-ended queue core: command front end and ring back end.
//
// Usage: each input word carries an operation in in_tuser (push front, push
// back, pop front, pop back, show) and, for pushes, the data word in in_tdata.
// Every push and pop gives one result word with a status in out_tuser (ok,
// empty, full) and, for a pop, the removed data in out_tdata. Show streams
// every stored word from front to back and raises out_tlast on the final
// one; an empty queue answers with a single empty status. Operation codes
// five to seven are accepted and dropped without a result.
// A push, or any empty or full answer, is registered in the command queue and
// then in the result queue before it is offered; a popped or shown word also
// passes through the registered read port of the store before it is queued.
// Throughput: the two-entry command queue takes a word per cycle while it has
// room. Pushes run one per cycle while the receiver keeps out_tready high; a
// push straight after a pop waits for the read in flight. A show holds the back
// end and reads the stored words in turn while the receiver keeps out_tready high.
// Reset clears the front pointer, fill count and both queues; the store
// itself is not cleared. When the receiver stalls, the result queue fills,
// the back end stops, and the command queue then drops in_tready.
`default_nettype none

module double_ended_queue_core #(
  parameter int CAPACITY = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // Input channel.
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // [31:0] value
  input  wire logic [2:0]  in_tuser,   // [2:0] kind
  // Result channel.
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // [31:0] word
  output logic [1:0]       out_tuser,  // [1:0] status
  output logic             out_tlast
);

  // Command hand-over between the two halves.
  logic          cmd_valid;
  logic          cmd_ready;
  dq_pkg::cmd_t  cmd;

  // The front end only classifies and buffers, so it never waits on the
  // back end except through the command queue filling up.
  dq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  // The back end owns the ring store and issues reads only when the result
  // queue is sure to have room for the data when it returns.
  dq_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule

`default_nettype wire
